// ===== sv/gif_lzw_code_stream_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// GIF LZW encoder assertion macros
// Shared property templates for the encoder's port checker.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_CODE_STREAM_ENCODER_MACROS_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define GIF_LZW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define GIF_LZW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gif_lzw_pkg.sv =====
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Shared widths, reserved codes, the code-op record and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gif_lzw_pkg;

  localparam int GIF_DICT_CODES = 4096;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 12;
  localparam int WIDTH_W  = 4;
  localparam int NC_W     = 13;
  localparam int BUF_W    = 20;
  localparam int CNT_W    = 5;
  localparam int NUM_ROOTS = 256;

  localparam int MAX_CODES   = 4;
  localparam int COUNT_W     = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CODE_W-1:0]  CLEAR_CODE  = 12'd256;
  localparam logic [CODE_W-1:0]  END_CODE    = 12'd257;
  localparam logic [NC_W-1:0]    FIRST_FREE  = 13'd258;
  localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;

  // codes for the packer, in emission order
  typedef struct packed {
    logic [MAX_CODES-1:0][CODE_W-1:0]  code;
    logic [MAX_CODES-1:0][WIDTH_W-1:0] width;
    logic [COUNT_W-1:0]                count;
    logic                              flush;
  } code_op_t;

  function automatic logic [NC_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    return (NC_W'(1) << w) - NC_W'(1);
  endfunction

  function automatic logic width_grows(input logic [WIDTH_W-1:0] w,
                                       input logic [NC_W-1:0] nc);
    return width_mask(w) < nc;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gif_lzw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/gif_lzw_dict.sv =====
// ----------------------------------------------------------------------------
// GIF LZW dictionary front end
// Takes symbols, looks up (prefix, symbol) pairs and turns each symbol into
// a possibly empty list of codes and widths for the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_dict #(
  parameter int DICT_CODES = gif_lzw_pkg::GIF_DICT_CODES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           symbol_valid,
  output logic                           symbol_stall,
  input  logic [gif_lzw_pkg::SYM_W-1:0]  symbol,
  input  logic                           image_last,
  output logic                           op_push,
  output gif_lzw_pkg::code_op_t          op,
  input  logic                           op_full
);

  import gif_lzw_pkg::*;

  localparam int RowW = $clog2(DICT_CODES);
  localparam int FwdDepth = DICT_CODES * NUM_ROOTS;
  localparam int FwdAw = RowW + SYM_W;

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  state_t state;

  logic                 hold_valid;
  logic [SYM_W-1:0]     hold_sym;
  logic                 hold_last;
  logic [SYM_W-1:0]     cur_sym;
  logic                 cur_last;
  logic [CODE_W-1:0]    prefix;
  logic [NC_W-1:0]      next_code;
  logic [WIDTH_W-1:0]   code_width;
  logic                 image_open;
  logic [NUM_ROOTS-1:0] root_valid;

  logic                 accept;
  logic                 lookup;
  logic                 leave;

  logic                 bm_we;
  logic [RowW-1:0]      bm_waddr;
  logic [NUM_ROOTS-1:0] bm_wdata;
  logic [NUM_ROOTS-1:0] bm_rdata;
  logic                 fwd_we;
  logic [FwdAw-1:0]     fwd_waddr;
  logic [FwdAw-1:0]     fwd_raddr;
  logic [CODE_W-1:0]    fwd_rdata;

  logic                 is_root;
  logic                 root_ok;
  logic [NUM_ROOTS-1:0] row;
  logic                 hit_bit;

  logic                 miss;
  logic                 clear_roots;
  logic [CODE_W-1:0]    prefix_next;
  logic [NC_W-1:0]      next_code_next;
  logic [WIDTH_W-1:0]   code_width_next;
  logic                 needs_enq;

  assign symbol_stall = hold_valid;
  assign accept = symbol_valid && !hold_valid;
  assign lookup = (state == S_IDLE) && hold_valid;
  assign leave  = (state == S_RESOLVE) && (!needs_enq || !op_full);
  assign op_push = (state == S_RESOLVE) && needs_enq && !op_full;

  // children bitmap per prefix code; rows of new codes are cleared at lookup
  gif_lzw_ram #(
    .WIDTH (NUM_ROOTS),
    .DEPTH (DICT_CODES)
  ) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (prefix[RowW-1:0]),
    .rdata (bm_rdata)
  );

  gif_lzw_ram #(
    .WIDTH (CODE_W),
    .DEPTH (FwdDepth)
  ) u_codes (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (next_code[CODE_W-1:0]),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  assign fwd_raddr = {prefix[RowW-1:0], (lookup ? hold_sym : cur_sym)};
  assign fwd_waddr = {prefix[RowW-1:0], cur_sym};
  assign fwd_we    = leave && miss;

  assign bm_we    = lookup || (leave && miss);
  assign bm_waddr = lookup ? next_code[RowW-1:0] : prefix[RowW-1:0];
  assign bm_wdata = lookup ? '0 : (row | (NUM_ROOTS'(1) << cur_sym));

  // root rows count as empty until written in this dictionary
  assign is_root = (prefix[CODE_W-1:SYM_W] == '0);
  assign root_ok = !is_root || root_valid[prefix[SYM_W-1:0]];
  assign row     = root_ok ? bm_rdata : '0;
  assign hit_bit = row[cur_sym];

  always_comb begin
    logic [COUNT_W-1:0] n;
    logic [1:0]         slot;
    logic [WIDTH_W-1:0] w;
    logic [NC_W-1:0]    nc;
    logic [CODE_W-1:0]  pfx;
    op          = '0;
    n           = '0;
    slot        = '0;
    w           = code_width;
    nc          = next_code;
    pfx         = prefix;
    miss        = 1'b0;
    clear_roots = 1'b0;
    if (!image_open) begin
      op.code[0]  = CLEAR_CODE;
      op.width[0] = START_WIDTH;
      n           = COUNT_W'(1);
      w           = START_WIDTH;
      nc          = FIRST_FREE;
      pfx         = {{(CODE_W-SYM_W){1'b0}}, cur_sym};
      clear_roots = 1'b1;
    end else if (hit_bit) begin
      pfx = fwd_rdata;
    end else begin
      miss        = 1'b1;
      op.code[0]  = prefix;
      op.width[0] = w;
      n           = COUNT_W'(1);
      if (width_grows(w, nc)) begin
        w = w + WIDTH_W'(1);
      end
      nc  = nc + NC_W'(1);
      pfx = {{(CODE_W-SYM_W){1'b0}}, cur_sym};
      if (nc >= NC_W'(DICT_CODES)) begin
        op.code[1]  = CLEAR_CODE;
        op.width[1] = w;
        n           = COUNT_W'(2);
        w           = START_WIDTH;
        nc          = FIRST_FREE;
        clear_roots = 1'b1;
      end
    end
    if (cur_last) begin
      slot           = n[1:0];
      op.code[slot]  = pfx;
      op.width[slot] = w;
      if (width_grows(w, nc)) begin
        w = w + WIDTH_W'(1);
      end
      slot           = slot + 2'd1;
      op.code[slot]  = END_CODE;
      op.width[slot] = w;
      n              = n + COUNT_W'(2);
      op.flush       = 1'b1;
    end
    op.count        = n;
    needs_enq       = (n != '0);
    prefix_next     = pfx;
    next_code_next  = nc;
    code_width_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hold_valid <= 1'b0;
      prefix     <= '0;
      next_code  <= FIRST_FREE;
      code_width <= START_WIDTH;
      image_open <= 1'b0;
      root_valid <= '0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (lookup) begin
        hold_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (lookup) begin
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          if (leave) begin
            state      <= S_IDLE;
            prefix     <= prefix_next;
            next_code  <= next_code_next;
            code_width <= code_width_next;
            image_open <= !cur_last;
            if (clear_roots) begin
              root_valid <= '0;
            end else if (miss && is_root) begin
              root_valid[prefix[SYM_W-1:0]] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_sym  <= symbol;
      hold_last <= image_last;
    end
    if (lookup) begin
      cur_sym  <= hold_sym;
      cur_last <= hold_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gif_lzw_fifo.sv =====
// ----------------------------------------------------------------------------
// GIF LZW code-op queue
// Short register FIFO between the dictionary and the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gif_lzw_pkg::code_op_t push_data,
  output logic                  full,
  input  logic                  pop,
  output gif_lzw_pkg::code_op_t head,
  output logic                  empty
);

  import gif_lzw_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  code_op_t      mem [QUEUE_DEPTH];
  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gif_lzw_pack.sv =====
// ----------------------------------------------------------------------------
// GIF LZW bit packer
// Appends codes LSB first to a bit buffer and sends whole bytes through an
// output register; pads the last partial byte of an image.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          op_valid,
  input  gif_lzw_pkg::code_op_t         op,
  output logic                          op_pop,
  output logic                          byte_valid,
  input  logic                          byte_stall,
  output logic [gif_lzw_pkg::SYM_W-1:0] out_byte,
  output logic                          run_last,
  output logic                          image_done
);

  import gif_lzw_pkg::*;

  logic [BUF_W-1:0]   bit_buf;
  logic [CNT_W-1:0]   bit_cnt;
  logic [COUNT_W-1:0] code_idx;

  logic [BUF_W-1:0]   bit_buf_next;
  logic [CNT_W-1:0]   bit_cnt_next;
  logic [COUNT_W-1:0] code_idx_next;

  logic               load_ok;
  logic               emit;
  logic [SYM_W-1:0]   emit_byte;
  logic               emit_last;
  logic               emit_done;

  logic [CODE_W-1:0]  cur_code;
  logic [WIDTH_W-1:0] cur_w;
  logic [NC_W-1:0]    mask_full;
  logic [CODE_W-1:0]  masked;
  logic [CNT_W-1:0]   rem;

  assign load_ok   = !byte_valid || !byte_stall;
  assign cur_code  = op.code[code_idx[1:0]];
  assign cur_w     = op.width[code_idx[1:0]];
  assign mask_full = width_mask(cur_w);
  assign masked    = cur_code & mask_full[CODE_W-1:0];
  assign rem       = bit_cnt - CNT_W'(8);

  always_comb begin
    bit_buf_next  = bit_buf;
    bit_cnt_next  = bit_cnt;
    code_idx_next = code_idx;
    op_pop        = 1'b0;
    emit          = 1'b0;
    emit_byte     = bit_buf[SYM_W-1:0];
    emit_last     = 1'b0;
    emit_done     = 1'b0;
    if (op_valid) begin
      if (bit_cnt >= CNT_W'(8)) begin
        if (load_ok) begin
          emit         = 1'b1;
          bit_buf_next = bit_buf >> 8;
          bit_cnt_next = rem;
          emit_last    = (code_idx == op.count) && (rem < CNT_W'(8)) &&
                         !(op.flush && (rem != '0));
          emit_done    = op.flush && emit_last;
        end
      end else if (code_idx < op.count) begin
        // append the next code above the held bits
        bit_buf_next  = bit_buf | (BUF_W'(masked) << bit_cnt);
        bit_cnt_next  = bit_cnt + CNT_W'(cur_w);
        code_idx_next = code_idx + COUNT_W'(1);
      end else if (op.flush && (bit_cnt != '0)) begin
        // pad the partial byte with zeros and close the image
        if (load_ok) begin
          emit          = 1'b1;
          emit_last     = 1'b1;
          emit_done     = 1'b1;
          bit_buf_next  = '0;
          bit_cnt_next  = '0;
          code_idx_next = '0;
          op_pop        = 1'b1;
        end
      end else begin
        code_idx_next = '0;
        op_pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf    <= '0;
      bit_cnt    <= '0;
      code_idx   <= '0;
      byte_valid <= 1'b0;
    end else begin
      bit_buf  <= bit_buf_next;
      bit_cnt  <= bit_cnt_next;
      code_idx <= code_idx_next;
      if (emit) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= emit_byte;
      run_last   <= emit_last;
      image_done <= emit_done;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gif_lzw_code_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// GIF LZW code stream encoder
// Pixel symbols in, packed GIF LZW code stream bytes out.
// ----------------------------------------------------------------------------
// Input channel: symbol plus image_last, taken when symbol_valid is high and
// symbol_stall is low. Output channel: out_byte with run_last (last byte a
// symbol causes) and image_done (last byte of an image), taken when
// byte_valid is high and byte_stall is low.
// A symbol can be taken while the one before it resolves, not while one waits
// for lookup: the lookup reads the child bitmap and code RAMs, resolves hit or
// miss in the next cycle, and its resolved prefix addresses the following lookup.
// Resolved codes wait in a 4-entry queue; the packer sends a byte whenever it
// holds eight bits and the output register can load, else appends the entry's
// next code, else closes the entry (the padding byte at image end closes its entry in the same cycle).
// Codes pass the hold register, lookup, resolve, queue and bit buffer to out_byte.
// Reset empties the dictionary at once (no clearing pass), closes the image
// and drops held bits; the next symbol opens an image with a clear code.
// When the receiver stalls, the output byte holds, the packer and then the
// queue fill, and symbol_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_code_stream_encoder #(
  parameter int DICT_CODES = gif_lzw_pkg::GIF_DICT_CODES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          symbol_valid,
  output logic                          symbol_stall,
  input  logic [gif_lzw_pkg::SYM_W-1:0] symbol,
  input  logic                          image_last,
  output logic                          byte_valid,
  input  logic                          byte_stall,
  output logic [gif_lzw_pkg::SYM_W-1:0] out_byte,
  output logic                          run_last,
  output logic                          image_done
);

  import gif_lzw_pkg::*;

  code_op_t q_in;
  code_op_t q_head;
  logic     q_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;

  gif_lzw_dict #(
    .DICT_CODES (DICT_CODES)
  ) u_dict (
    .clk          (clk),
    .rst          (rst),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol),
    .image_last   (image_last),
    .op_push      (q_push),
    .op           (q_in),
    .op_full      (q_full)
  );

  gif_lzw_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  gif_lzw_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (!q_empty),
    .op         (q_head),
    .op_pop     (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .image_done (image_done)
  );

endmodule

`default_nettype wire

// ===== sv/gif_lzw_checker.sv =====
// ----------------------------------------------------------------------------
// GIF LZW encoder port checker
// Watches the encoder's ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gif_lzw_code_stream_encoder_macros.svh"

module gif_lzw_checker (
  input logic       clk,
  input logic       rst,
  input logic       symbol_valid,
  input logic       symbol_stall,
  input logic [7:0] symbol,
  input logic       image_last,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       image_done
);

  logic sym_take;
  logic out_held;

  assign sym_take = symbol_valid && !symbol_stall;
  assign out_held = byte_valid && byte_stall;

  // a taken symbol sits in the hold register, so symbol_stall is high in the next cycle
  `GIF_LZW_ASSERT_NEXT(a_sym_spacing, clk, rst, sym_take, symbol_stall, "symbol taken on consecutive cycles")
  // the image's final byte also closes its symbol's run
  `GIF_LZW_ASSERT_NOW(a_done_is_last, clk, rst, byte_valid && image_done, run_last, "image_done without run_last")
  `GIF_LZW_ASSERT_NEXT(a_valid_hold, clk, rst, out_held, byte_valid, "byte_valid dropped while stalled")
  `GIF_LZW_ASSERT_NEXT(a_byte_hold, clk, rst, out_held, $stable(out_byte) && $stable(run_last) && $stable(image_done), "byte payload changed while stalled")

endmodule

bind gif_lzw_code_stream_encoder gif_lzw_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .symbol_valid (symbol_valid),
  .symbol_stall (symbol_stall),
  .symbol       (symbol),
  .image_last   (image_last),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .out_byte     (out_byte),
  .run_last     (run_last),
  .image_done   (image_done)
);

`default_nettype wire
